// ===== rtl/sspwm_pkg.sv =====
// Shared constants for the serial steering to dual PWM block.
// Holds widths of the bit-serial arithmetic units, register indexes and character codes.
// No dependencies.
package sspwm_pkg;

	localparam int unsigned DVD_W     = 46;
	localparam int unsigned DVR_W     = 14;
	localparam int unsigned QUO_W     = 24;
	localparam int unsigned DIV_CNT_W = $clog2(DVD_W + 1);

	localparam int unsigned MCD_W     = 30;
	localparam int unsigned MPR_W     = 16;
	localparam int unsigned PRD_W     = MCD_W + MPR_W;
	localparam int unsigned MUL_CNT_W = $clog2(MPR_W + 1);

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SCAN_WIDTH    = 3'd0;
	localparam cfg_idx_t REG_LEFT_BOUND    = 3'd1;
	localparam cfg_idx_t REG_RIGHT_BOUND   = 3'd2;
	localparam cfg_idx_t REG_STALL_PERCENT = 3'd3;
	localparam cfg_idx_t REG_PWM_TOP       = 3'd4;

	localparam logic [11:0] RST_SCAN_WIDTH    = 12'd640;
	localparam logic [6:0]  RST_LEFT_BOUND    = 7'd40;
	localparam logic [6:0]  RST_RIGHT_BOUND   = 7'd60;
	localparam logic [6:0]  RST_STALL_PERCENT = 7'd75;
	localparam logic [15:0] RST_PWM_TOP       = 16'd3000;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

endpackage

// ===== rtl/sspwm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sspwm_pkg for its widths.
module sspwm_div import sspwm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVR_W-1:0] divisor,
	output logic [QUO_W-1:0] quotient,
	output logic             overflow,
	output logic             done
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVR_W-1:0]     dvr_q;
	logic [DVR_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 ovf_q;
	logic [DVR_W:0]       trial;
	logic [DVR_W:0]       diff;
	logic                 qbit;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = (trial >= {1'b0, dvr_q});
	assign diff  = trial - {1'b0, dvr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], qbit};
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	assign quotient = quo_q;
	assign overflow = ovf_q;
	assign done     = done_q;

endmodule

// ===== rtl/sspwm_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, most significant first.
// Depends on sspwm_pkg for its widths.
module sspwm_mul import sspwm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MCD_W-1:0] mcand,
	input  logic [MPR_W-1:0] mplier,
	output logic [PRD_W-1:0] product,
	output logic             done
);

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MCD_W-1:0]     mcd_q;
	logic [MPR_W-1:0]     mpr_q;
	logic [PRD_W-1:0]     acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= MUL_CNT_W'(MPR_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - MUL_CNT_W'(1);
			if (cnt_q == MUL_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcd_q <= mcand;
			mpr_q <= mplier;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[PRD_W-2:0], 1'b0} + (mpr_q[MPR_W-1] ? PRD_W'(mcd_q) : '0);
			mpr_q <= {mpr_q[MPR_W-2:0], 1'b0};
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

// ===== rtl/serial_steer_to_dual_pwm.sv =====
// Sequence: a plain character gives no result. A terminator starts the work: the 46-step divider
// runs three times (percent, left level, right level) and the 16-step multiplier twice; when the
// percent is zero, only the percent division runs before the result is offered.
// Throughput: one character per cycle; input is held off while a terminator is worked on and
// while its result waits. Reset is asynchronous: registers to defaults, position to zero.
// Depends on sspwm_pkg, sspwm_div and sspwm_mul.
module serial_steer_to_dual_pwm import sspwm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           left_level,
	output logic                  left_reverse,
	output logic [15:0]           right_level,
	output logic                  right_reverse
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_PDIV  = 10'b0000000010,
		ST_PWAIT = 10'b0000000100,
		ST_STEER = 10'b0000001000,
		ST_MPREP = 10'b0000010000,
		ST_MUL   = 10'b0000100000,
		ST_MWAIT = 10'b0001000000,
		ST_LDIV  = 10'b0010000000,
		ST_LWAIT = 10'b0100000000,
		ST_PUSH  = 10'b1000000000
	} seq_state_t;

	typedef enum logic [3:0] {
		PH_SKIP   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} parse_phase_t;

	logic [11:0] scan_width_q;
	logic [6:0]  left_bound_q;
	logic [6:0]  right_bound_q;
	logic [6:0]  stall_percent_q;
	logic [15:0] pwm_top_q;

	seq_state_t   state_q;
	parse_phase_t phase_q;
	logic         side_q;
	logic         out_valid_q;
	logic [15:0]  accum_q;
	logic         neg_q;
	logic         seen_q;
	logic         pos_neg_q;
	logic [15:0]  pos_mag_q;

	logic [23:0]      vl_q;
	logic [23:0]      vr_q;
	logic [6:0]       dl_q;
	logic [6:0]       dr_q;
	logic [MCD_W-1:0] m_q;
	logic [15:0]      res_l_lvl_q;
	logic [15:0]      res_r_lvl_q;
	logic             res_l_rev_q;
	logic             res_r_rev_q;
	logic [15:0]      left_level_q;
	logic [15:0]      right_level_q;
	logic             left_reverse_q;
	logic             right_reverse_q;

	logic        in_acc;
	logic        is_term;
	logic        is_digit;
	logic        is_blank;
	logic [19:0] acc_sum;
	logic [15:0] accum_next;
	logic        push_go;

	logic             div_start;
	logic [DVD_W-1:0] div_dividend;
	logic [DVR_W-1:0] div_divisor;
	logic [QUO_W-1:0] div_quo;
	logic             div_ovf;
	logic             div_done;
	logic             mul_start;
	logic [PRD_W-1:0] mul_product;
	logic             mul_done;

	logic [22:0] pos_x100;
	logic [11:0] sw_eff;
	logic [22:0] p_mag;
	logic [23:0] p_s;
	logic        p_zero;
	logic [6:0]  lb_eff;
	logic [6:0]  rb_eff;
	logic        le_lb;
	logic        ge_rb;
	logic        ramp_r;
	logic [23:0] v_right;

	logic [23:0]        cur_v;
	logic [6:0]         cur_den;
	logic [DVR_W-1:0]   den_x100;
	logic signed [7:0]  y_s;
	logic [24:0]        k_v;
	logic [24:0]        k_abs;
	logic [7:0]         y_abs;
	logic [MCD_W-1:0]   ky;
	logic signed [15:0] vy_s;
	logic [13:0]        ds;
	logic signed [16:0] b_s;
	logic               v_pos;
	logic               same_sign;
	logic [MCD_W-1:0]   m_next;
	logic [15:0]        lvl_sat;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign is_term  = (rx_byte == CH_NUL) || (rx_byte == CH_CR);
	assign is_digit = rx_byte inside {[CH_ZERO:CH_NINE]};
	assign is_blank = rx_byte inside {CH_SPACE, [CH_TAB:CH_FF]};

	assign acc_sum    = 20'({accum_q, 3'b000}) + 20'({accum_q, 1'b0}) + 20'(rx_byte[3:0]);
	assign accum_next = (|acc_sum[19:16]) ? 16'hFFFF : acc_sum[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_width_q    <= RST_SCAN_WIDTH;
			left_bound_q    <= RST_LEFT_BOUND;
			right_bound_q   <= RST_RIGHT_BOUND;
			stall_percent_q <= RST_STALL_PERCENT;
			pwm_top_q       <= RST_PWM_TOP;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SCAN_WIDTH:    scan_width_q    <= cfg_wdata[11:0];
				REG_LEFT_BOUND:    left_bound_q    <= cfg_wdata[6:0];
				REG_RIGHT_BOUND:   right_bound_q   <= cfg_wdata[6:0];
				REG_STALL_PERCENT: stall_percent_q <= cfg_wdata[6:0];
				REG_PWM_TOP:       pwm_top_q       <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// The number parser follows a %d conversion: blanks, one sign, then digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q   <= '0;
			neg_q     <= 1'b0;
			seen_q    <= 1'b0;
			phase_q   <= PH_SKIP;
			pos_neg_q <= 1'b0;
			pos_mag_q <= '0;
		end else if (in_acc) begin
			if (is_term) begin
				if (seen_q) begin
					pos_neg_q <= neg_q;
					pos_mag_q <= accum_q;
				end
				accum_q <= '0;
				neg_q   <= 1'b0;
				seen_q  <= 1'b0;
				phase_q <= PH_SKIP;
			end else begin
				case (phase_q)
					PH_SKIP: begin
						if (!is_blank) begin
							if (rx_byte == CH_MINUS) begin
								neg_q   <= 1'b1;
								phase_q <= PH_SIGN;
							end else if (rx_byte == CH_PLUS) begin
								phase_q <= PH_SIGN;
							end else if (is_digit) begin
								accum_q <= accum_next;
								seen_q  <= 1'b1;
								phase_q <= PH_DIGITS;
							end else begin
								phase_q <= PH_DONE;
							end
						end
					end
					PH_SIGN, PH_DIGITS: begin
						if (is_digit) begin
							accum_q <= accum_next;
							seen_q  <= 1'b1;
							phase_q <= PH_DIGITS;
						end else begin
							phase_q <= PH_DONE;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign pos_x100 = 23'({pos_mag_q, 6'b0}) + 23'({pos_mag_q, 5'b0}) + 23'({pos_mag_q, 2'b0});
	assign sw_eff   = (scan_width_q == 12'd0) ? 12'd1 : scan_width_q;

	assign p_mag   = div_quo[22:0];
	assign p_s     = pos_neg_q ? (24'd0 - {1'b0, p_mag}) : {1'b0, p_mag};
	assign p_zero  = (p_mag == 23'd0);
	assign lb_eff  = (left_bound_q == 7'd0) ? 7'd1 : left_bound_q;
	assign rb_eff  = (right_bound_q > 7'd99) ? 7'd99 : right_bound_q;
	assign le_lb   = $signed(p_s) <= $signed({17'd0, lb_eff});
	assign ge_rb   = $signed(p_s) >= $signed({17'd0, rb_eff});
	assign ramp_r  = !le_lb && ge_rb;
	assign v_right = 24'd100 - p_s;

	// A side command is v/den in hundredths. A forward command scales as v*(100-s)+den*s;
	// a reverse one as (den+v)*(100-s), which only counts when that product is positive.
	assign cur_v    = side_q ? vr_q : vl_q;
	assign cur_den  = side_q ? dr_q : dl_q;
	assign den_x100 = DVR_W'({cur_den, 6'b0}) + DVR_W'({cur_den, 5'b0})
		+ DVR_W'({cur_den, 2'b0});
	assign y_s      = 8'sd100 - $signed({1'b0, stall_percent_q});
	assign k_v      = {cur_v[23], cur_v} + {18'd0, cur_den};
	assign k_abs    = k_v[24] ? (25'd0 - k_v) : k_v;
	assign y_abs    = y_s[7] ? (8'd0 - y_s) : y_s;
	assign ky       = MCD_W'(k_abs[22:0]) * MCD_W'(y_abs[6:0]);
	assign vy_s     = $signed(cur_v[7:0]) * y_s;
	assign ds       = 14'(cur_den) * 14'(stall_percent_q);
	assign b_s      = $signed({vy_s[15], vy_s}) + $signed({3'b000, ds});
	assign v_pos    = !cur_v[23] && (cur_v != 24'd0);
	assign same_sign = (k_v[24] && y_s[7])
		|| (!k_v[24] && (k_v != 25'd0) && !y_s[7] && (y_s != 8'sd0));

	always_comb begin
		m_next = '0;
		if (v_pos) begin
			if (b_s > 17'sd0) begin
				m_next = MCD_W'(b_s[15:0]);
			end
		end else if (cur_v[23] && same_sign) begin
			m_next = ky;
		end
	end

	assign lvl_sat = (div_ovf || (|div_quo[QUO_W-1:16])) ? 16'hFFFF : div_quo[15:0];

	assign div_start    = (state_q == ST_PDIV) || (state_q == ST_LDIV);
	assign div_dividend = (state_q == ST_PDIV) ? DVD_W'(pos_x100) : DVD_W'(mul_product);
	assign div_divisor  = (state_q == ST_PDIV) ? DVR_W'(sw_eff) : den_x100;
	assign mul_start    = (state_q == ST_MUL);
	assign push_go      = (state_q == ST_PUSH) && (!out_valid_q || out_ready);

	sspwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.overflow (div_ovf),
		.done     (div_done)
	);

	sspwm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (m_q),
		.mplier  (pwm_top_q),
		.product (mul_product),
		.done    (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && is_term) begin
						state_q <= ST_PDIV;
					end
				end
				ST_PDIV: state_q <= ST_PWAIT;
				ST_PWAIT: begin
					if (div_done) begin
						state_q <= ST_STEER;
					end
				end
				ST_STEER: begin
					side_q <= 1'b0;
					if (p_zero) begin
						state_q <= ST_PUSH;
					end else begin
						state_q <= ST_MPREP;
					end
				end
				ST_MPREP: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (mul_done) begin
						state_q <= ST_LDIV;
					end
				end
				ST_LDIV: state_q <= ST_LWAIT;
				ST_LWAIT: begin
					if (div_done) begin
						if (side_q) begin
							state_q <= ST_PUSH;
						end else begin
							side_q  <= 1'b1;
							state_q <= ST_MPREP;
						end
					end
				end
				ST_PUSH: begin
					if (push_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_STEER) begin
			vl_q        <= le_lb ? p_s : 24'd1;
			dl_q        <= le_lb ? lb_eff : 7'd1;
			vr_q        <= ramp_r ? v_right : 24'd1;
			dr_q        <= ramp_r ? (7'd100 - rb_eff) : 7'd1;
			res_l_lvl_q <= '0;
			res_r_lvl_q <= '0;
			res_l_rev_q <= 1'b0;
			res_r_rev_q <= 1'b0;
		end
		if (state_q == ST_MPREP) begin
			m_q <= m_next;
			if (side_q) begin
				res_r_rev_q <= cur_v[23];
			end else begin
				res_l_rev_q <= cur_v[23];
			end
		end
		if ((state_q == ST_LWAIT) && div_done) begin
			if (side_q) begin
				res_r_lvl_q <= lvl_sat;
			end else begin
				res_l_lvl_q <= lvl_sat;
			end
		end
		if (push_go) begin
			left_level_q    <= res_l_lvl_q;
			left_reverse_q  <= res_l_rev_q;
			right_level_q   <= res_r_lvl_q;
			right_reverse_q <= res_r_rev_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_level    = left_level_q;
	assign left_reverse  = left_reverse_q;
	assign right_level   = right_level_q;
	assign right_reverse = right_reverse_q;

endmodule
